// ===== hdl/kmpq_pkg.sv =====
// ----------------------------------------------------------------------------
// kmpq_pkg: shared types and constants of the keyed min-priority queue
// Request and response payloads, request and status codes, control state
// encoding and the control bundle for the serial min-search unit.
// ----------------------------------------------------------------------------
package kmpq_pkg;

  localparam int NUM_KEYS      = 64;
  localparam int PRIORITY_BITS = 32;

  typedef enum logic [2:0] {
    MODE_SET      = 3'd0,
    MODE_REMOVE   = 3'd1,
    MODE_POP      = 3'd2,
    MODE_PEEK     = 3'd3,
    MODE_CONTAINS = 3'd4
  } kmpq_mode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_EMPTY     = 2'd2
  } kmpq_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET,
    S_PRIO,
    S_KEY,
    S_DONE
  } kmpq_state_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic [5:0]         item_key;
    logic signed [31:0] item_priority;
  } kmpq_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         out_key;
    logic signed [31:0] out_priority;
    logic               present;
    logic [6:0]         live_count;
  } kmpq_rsp_t;

  // Control of the serial min-search unit for one cycle
  typedef struct packed {
    logic init;       // start a search: candidates = queued keys
    logic load;       // load the priority shift register for a set
    logic shift_out;  // shift one priority bit out, MSB first
    logic step_prio;  // eliminate on one priority bit plane
    logic step_key;   // eliminate on one key index bit
    logic pref;       // bit value that wins this step
  } kmpq_elim_ctrl_t;

endpackage

// ===== hdl/kmpq_plane_mem.sv =====
// ----------------------------------------------------------------------------
// kmpq_plane_mem: bit-plane priority memory
// One row per priority bit, one column per key. One write port and one
// read port, read data registered.
// ----------------------------------------------------------------------------
module kmpq_plane_mem #(
  parameter int Width = 64,
  parameter int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/kmpq_elim.sv =====
// ----------------------------------------------------------------------------
// kmpq_elim: serial min-search unit
// Eliminates candidate keys one bit per cycle, priority MSB first and then
// key index MSB first; the winning bits shift into the result registers.
// Also holds the priority shift register that feeds a set.
// ----------------------------------------------------------------------------
module kmpq_elim
  import kmpq_pkg::*;
#(
  parameter int NumKeys  = NUM_KEYS,
  parameter int PrioBits = PRIORITY_BITS,
  localparam int KeyBits = $clog2(NumKeys),
  localparam int KeyIdxW = (KeyBits > 1) ? $clog2(KeyBits) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kmpq_elim_ctrl_t     ctrl_i,
  input  logic [NumKeys-1:0]  valid_i,
  input  logic [NumKeys-1:0]  plane_i,
  input  logic [KeyIdxW-1:0]  key_bit_i,
  input  logic [PrioBits-1:0] load_val_i,
  output logic [NumKeys-1:0]  cand_o,
  output logic [PrioBits-1:0] prio_o,
  output logic [KeyBits-1:0]  key_o,
  output logic                prio_msb_o
);

  logic [NumKeys-1:0]  cand_q, cand_d;
  logic [NumKeys-1:0]  key_row;
  logic [NumKeys-1:0]  row;
  logic [NumKeys-1:0]  match;
  logic                any_match;
  logic                win_bit;
  logic [PrioBits-1:0] prio_sr_q;
  logic [KeyBits-1:0]  key_sr_q;

  // Key index bit of each lane for the current key step
  for (genvar gi = 0; gi < NumKeys; gi++) begin : g_lane
    localparam logic [KeyBits-1:0] LaneIdx = KeyBits'(gi);
    assign key_row[gi] = LaneIdx[key_bit_i];
  end

  assign row       = ctrl_i.step_key ? key_row : plane_i;
  assign match     = cand_q & (ctrl_i.pref ? row : ~row);
  assign any_match = |match;
  // Survivors all share the winning bit
  assign win_bit   = any_match ? ctrl_i.pref : ~ctrl_i.pref;

  always_comb begin
    cand_d = cand_q;
    if (ctrl_i.init) begin
      cand_d = valid_i;
    end else if ((ctrl_i.step_prio || ctrl_i.step_key) && any_match) begin
      cand_d = match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
    end else begin
      cand_q <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prio_sr_q <= load_val_i;
    end else if (ctrl_i.shift_out) begin
      prio_sr_q <= PrioBits'({prio_sr_q, 1'b0});
    end else if (ctrl_i.step_prio) begin
      prio_sr_q <= PrioBits'({prio_sr_q, win_bit});
    end
    if (ctrl_i.step_key) begin
      key_sr_q <= KeyBits'({key_sr_q, win_bit});
    end
  end

  assign cand_o     = cand_q;
  assign prio_o     = prio_sr_q;
  assign key_o      = key_sr_q;
  assign prio_msb_o = prio_sr_q[PrioBits-1];

endmodule

// ===== hdl/keyed_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// keyed_min_priority_queue: keyed min-priority queue over key indices
// Set, remove, pop, peek and contains over NumKeys keys with signed
// priorities; every transaction in gives exactly one transaction out.
// ----------------------------------------------------------------------------
// Priorities live in a bit-plane memory (one row per priority bit, one
// column per key) and are handled one bit per cycle. A set walks all
// PrioBits planes once, read-modify-write. Pop and peek search all queued
// keys at once by elimination: first over the priority planes (sign plane
// first), then over the key index bits so that the lowest key wins ties.
// Remove, contains, unused request codes and pop or peek on an empty queue
// go straight to completion. The memory gives one plane read per cycle.
// One request is in work at a time; a new one is taken as soon as the
// previous result sits in the output register, even if not yet taken.
// ----------------------------------------------------------------------------
module keyed_min_priority_queue
  import kmpq_pkg::*;
#(
  parameter int NumKeys  = NUM_KEYS,
  parameter int PrioBits = PRIORITY_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  kmpq_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output kmpq_rsp_t out_data_o
);

  localparam int KeyBits  = $clog2(NumKeys);
  localparam int KeyIdxW  = (KeyBits > 1) ? $clog2(KeyBits) : 1;
  localparam int KeyExtW  = (KeyBits > 6) ? KeyBits : 6;
  localparam int PlW      = $clog2(PrioBits);
  localparam int StepMax  = (PrioBits > KeyBits) ? PrioBits : KeyBits;
  localparam int StepW    = $clog2(StepMax);
  localparam int CntW     = $clog2(NumKeys + 1);

  kmpq_state_e       state_q, state_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  kmpq_req_t         req_q, req_d;
  logic [NumKeys-1:0] valid_q, valid_d;
  logic [CntW-1:0]   count_q, count_d;
  kmpq_rsp_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  kmpq_elim_ctrl_t   ectl;
  logic              mem_we;
  logic [PlW-1:0]    mem_waddr;
  logic [PlW-1:0]    mem_raddr;
  logic [NumKeys-1:0] mem_wdata;
  logic [NumKeys-1:0] mem_rdata;
  logic [NumKeys-1:0] cand;
  logic [PrioBits-1:0] srch_prio;
  logic [KeyBits-1:0] srch_key;
  logic              prio_msb;

  logic [KeyExtW-1:0] req_key_ext;
  logic [KeyBits-1:0] req_key;
  logic              req_key_ok;
  logic              in_key_ok;
  logic [NumKeys-1:0] key_mask;
  logic              out_free;

  // Key decode: keys at or beyond NumKeys count as absent
  assign req_key_ext = KeyExtW'(req_q.item_key);
  assign req_key     = req_key_ext[KeyBits-1:0];
  assign req_key_ok  = 32'(req_q.item_key) < 32'(NumKeys);
  assign in_key_ok   = 32'(in_data_i.item_key) < 32'(NumKeys);
  assign key_mask    = NumKeys'(1) << req_key;
  assign out_free    = !out_valid_q || out_ready_i;

  kmpq_plane_mem #(
    .Width (NumKeys),
    .Depth (PrioBits)
  ) u_plane_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  kmpq_elim #(
    .NumKeys  (NumKeys),
    .PrioBits (PrioBits)
  ) u_elim (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ectl),
    .valid_i    (valid_q),
    .plane_i    (mem_rdata),
    .key_bit_i  (KeyIdxW'(cnt_q)),
    .load_val_i (PrioBits'(in_data_i.item_priority)),
    .cand_o     (cand),
    .prio_o     (srch_prio),
    .key_o      (srch_key),
    .prio_msb_o (prio_msb)
  );

  // Patch this key's column of the plane just read
  assign mem_wdata = prio_msb ? (mem_rdata | key_mask) : (mem_rdata & ~key_mask);
  assign mem_waddr = PlW'(cnt_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    req_d       = req_q;
    valid_d     = valid_q;
    count_d     = count_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ectl        = '0;
    mem_we      = 1'b0;
    mem_raddr   = PlW'(cnt_q - 1'b1);
    in_ready_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        mem_raddr  = PlW'(PrioBits - 1);
        if (in_valid_i) begin
          req_d   = in_data_i;
          cnt_d   = StepW'(PrioBits - 1);
          state_d = S_DONE;
          case (in_data_i.mode)
            MODE_SET: begin
              // Start the plane walk; an out-of-range key just completes
              if (in_key_ok) begin
                ectl.load = 1'b1;
                state_d   = S_SET;
              end
            end
            MODE_POP, MODE_PEEK: begin
              if (count_q != '0) begin
                ectl.init = 1'b1;
                state_d   = S_PRIO;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SET: begin
        // Write back the plane read last cycle, read the next one
        mem_we         = 1'b1;
        ectl.shift_out = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end

      S_PRIO: begin
        // Sign plane prefers ones, all lower planes prefer zeros
        ectl.step_prio = 1'b1;
        ectl.pref      = (cnt_q == StepW'(PrioBits - 1));
        if (cnt_q == '0) begin
          cnt_d   = StepW'(KeyBits - 1);
          state_d = S_KEY;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end

      S_KEY: begin
        // Break ties toward the lowest key index
        ectl.step_key = 1'b1;
        ectl.pref     = 1'b0;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end

      S_DONE: begin
        // Commit the state update together with loading the output register
        if (out_free) begin
          out_d              = '0;
          out_d.status       = STAT_OK;
          case (req_q.mode)
            MODE_SET: begin
              if (req_key_ok && !valid_q[req_key]) begin
                valid_d[req_key] = 1'b1;
                count_d          = count_q + 1'b1;
              end
            end
            MODE_REMOVE: begin
              if (req_key_ok && valid_q[req_key]) begin
                valid_d[req_key] = 1'b0;
                count_d          = count_q - 1'b1;
              end else begin
                out_d.status = STAT_NOT_FOUND;
              end
            end
            MODE_POP, MODE_PEEK: begin
              if (count_q == '0) begin
                out_d.status = STAT_EMPTY;
              end else begin
                out_d.out_key      = 6'(srch_key);
                out_d.out_priority = 32'($signed(srch_prio));
                if (req_q.mode == MODE_POP) begin
                  valid_d = valid_q & ~cand;
                  count_d = count_q - 1'b1;
                end
              end
            end
            MODE_CONTAINS: begin
              out_d.present = req_key_ok && valid_q[req_key];
            end
            default: begin
              out_d.status = STAT_OK;
            end
          endcase
          out_d.live_count = 7'(count_d);
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the request and result payloads
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The live count always matches the number of queued keys
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) == $countones(valid_q))
    else $error("live count out of step with queued keys");

  // A finished search over a non-empty queue leaves exactly one winner
  a_single_winner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && count_q != '0 &&
     (req_q.mode == MODE_POP || req_q.mode == MODE_PEEK)) |-> $onehot(cand))
    else $error("min search did not end with one candidate");

  // A plane walk only runs for a key in range
  a_set_key_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SET) |-> req_key_ok)
    else $error("plane walk for an out-of-range key");

  // A new result only comes from the completion step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside completion");

endmodule
